@@ rtl/plob_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_pkg
// Shared constants, status codes and control structs of the price-level book.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int LEVELS_DEF     = 100;
  localparam int PRICE_BITS_DEF = 32;
  localparam int QTY_BITS_DEF   = 48;

  // result status codes
  localparam logic [1:0] ST_APPLIED  = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_CLEARED  = 2'd2;

  // command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // side codes
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // per-side control from the sequencer
  typedef struct packed {
    logic cmp;    // compare every cell against the key
    logic apply;  // apply the update to this side
    logic clear;  // empty this side
  } side_ctl_t;

  // per-cell control from the side chain
  typedef struct packed {
    logic cmp;    // latch ahead/match flags
    logic upd;    // overwrite quantity at the matching cell
    logic ers;    // shift toward the head from the erase point
    logic ins;    // shift toward the tail and load the key at the insert point
  } cell_ctl_t;

endpackage

@@ rtl/plob_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_if
// Valid/ready channels of the price-level book: level items in, reports out.
// ----------------------------------------------------------------------------
interface plob_in_if #(
  parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS   = plob_pkg::QTY_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic                  side;
  logic [PRICE_BITS-1:0] level_price;
  logic [QTY_BITS-1:0]   level_qty;

  modport source (output valid, cmd, side, level_price, level_qty, input ready);
  modport sink   (input valid, cmd, side, level_price, level_qty, output ready);
endinterface

interface plob_out_if #(
  parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS   = plob_pkg::QTY_BITS_DEF,
  parameter int CNT_BITS   = $clog2(plob_pkg::LEVELS_DEF + 1)
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [PRICE_BITS-1:0]        top_bid_price;
  logic [QTY_BITS-1:0]          best_bid_qty;
  logic [PRICE_BITS-1:0]        top_ask_price;
  logic [QTY_BITS-1:0]          best_ask_qty;
  logic [CNT_BITS-1:0]          bid_count;
  logic [CNT_BITS-1:0]          ask_count;
  logic                         book_valid;
  logic signed [PRICE_BITS:0]   spread;

  modport source (output valid, status, top_bid_price, best_bid_qty, top_ask_price,
                  best_ask_qty, bid_count, ask_count, book_valid, spread,
                  input ready);
  modport sink   (input valid, status, top_bid_price, best_bid_qty, top_ask_price,
                  best_ask_qty, bid_count, ask_count, book_valid, spread,
                  output ready);
endinterface

@@ rtl/plob_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_cell
// One price level of a sorted side: compares against the key, then shifts,
// loads or overwrites in step with its neighbors.
// ----------------------------------------------------------------------------
module plob_cell #(
  parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS   = plob_pkg::QTY_BITS_DEF,
  parameter int CNT_BITS   = $clog2(plob_pkg::LEVELS_DEF + 1),
  parameter int IDX        = 0,
  parameter bit IS_ASK     = 1'b0
) (
  input  logic                    clk,
  input  plob_pkg::cell_ctl_t     ctl,
  input  logic [CNT_BITS-1:0]     count,
  input  logic [PRICE_BITS-1:0]   key_price,
  input  logic [QTY_BITS-1:0]     key_qty,
  input  logic                    left_ahead,
  input  logic [PRICE_BITS-1:0]   left_price,
  input  logic [QTY_BITS-1:0]     left_qty,
  input  logic [PRICE_BITS-1:0]   right_price,
  input  logic [QTY_BITS-1:0]     right_qty,
  output logic [PRICE_BITS-1:0]   price,
  output logic [QTY_BITS-1:0]     qty,
  output logic                    ahead,
  output logic                    match
);

  logic [PRICE_BITS-1:0] price_r;
  logic [QTY_BITS-1:0]   qty_r;
  logic                  ahead_r;
  logic                  match_r;
  logic                  held;
  logic                  better;

  // entries below the count are held; the rest are stale
  assign held   = count > CNT_BITS'(IDX);
  assign better = IS_ASK ? (price_r < key_price) : (price_r > key_price);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      ahead_r <= held && better;
      match_r <= held && (price_r == key_price);
    end
    if (ctl.upd && match_r) begin
      qty_r <= key_qty;
    end
    if (ctl.ers && !ahead_r) begin
      price_r <= right_price;
      qty_r   <= right_qty;
    end
    // the first cell not ahead takes the key; the ones behind it shift back
    if (ctl.ins && !ahead_r) begin
      if (left_ahead) begin
        price_r <= key_price;
        qty_r   <= key_qty;
      end else begin
        price_r <= left_price;
        qty_r   <= left_qty;
      end
    end
  end

  assign price = price_r;
  assign qty   = qty_r;
  assign ahead = ahead_r;
  assign match = match_r;

endmodule

@@ rtl/plob_side.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_side
// One side of the book: a chain of level cells kept sorted best first, plus
// the count of levels held.
// ----------------------------------------------------------------------------
module plob_side #(
  parameter int LEVELS     = plob_pkg::LEVELS_DEF,
  parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS   = plob_pkg::QTY_BITS_DEF,
  parameter int CNT_BITS   = $clog2(LEVELS + 1),
  parameter bit IS_ASK     = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  plob_pkg::side_ctl_t     ctl,
  input  logic [PRICE_BITS-1:0]   key_price,
  input  logic [QTY_BITS-1:0]     key_qty,
  output logic [PRICE_BITS-1:0]   head_price,
  output logic [QTY_BITS-1:0]     head_qty,
  output logic [CNT_BITS-1:0]     count
);

  logic [CNT_BITS-1:0]   count_r;
  logic [CNT_BITS-1:0]   count_nxt;
  logic [PRICE_BITS-1:0] price_a [LEVELS];
  logic [QTY_BITS-1:0]   qty_a   [LEVELS];
  logic [LEVELS-1:0]     ahead_a;
  logic [LEVELS-1:0]     match_a;
  logic                  match_any;
  logic                  qty_zero;
  plob_pkg::cell_ctl_t   cell_ctl;

  assign match_any = |match_a;
  assign qty_zero  = key_qty == '0;

  always_comb begin
    cell_ctl.cmp = ctl.cmp;
    cell_ctl.upd = ctl.apply && match_any && !qty_zero;
    cell_ctl.ers = ctl.apply && match_any && qty_zero;
    // a key worse than every held level of a full side is dropped
    cell_ctl.ins = ctl.apply && !match_any && !qty_zero && !ahead_a[LEVELS-1];
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (cell_ctl.ers) begin
      count_nxt = count_r - CNT_BITS'(1);
    end else if (cell_ctl.ins && (count_r != CNT_BITS'(LEVELS))) begin
      count_nxt = count_r + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic                  l_ahead;
    logic [PRICE_BITS-1:0] l_price;
    logic [QTY_BITS-1:0]   l_qty;
    logic [PRICE_BITS-1:0] r_price;
    logic [QTY_BITS-1:0]   r_qty;

    if (i == 0) begin : g_head
      assign l_ahead = 1'b0;
      assign l_price = key_price;
      assign l_qty   = key_qty;
    end else begin : g_mid
      assign l_ahead = ahead_a[i-1];
      assign l_price = price_a[i-1];
      assign l_qty   = qty_a[i-1];
    end

    if (i == LEVELS - 1) begin : g_tail
      assign r_price = price_a[i];
      assign r_qty   = qty_a[i];
    end else begin : g_body
      assign r_price = price_a[i+1];
      assign r_qty   = qty_a[i+1];
    end

    plob_cell #(
      .PRICE_BITS (PRICE_BITS),
      .QTY_BITS   (QTY_BITS),
      .CNT_BITS   (CNT_BITS),
      .IDX        (i),
      .IS_ASK     (IS_ASK)
    ) u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .count       (count_r),
      .key_price   (key_price),
      .key_qty     (key_qty),
      .left_ahead  (l_ahead),
      .left_price  (l_price),
      .left_qty    (l_qty),
      .right_price (r_price),
      .right_qty   (r_qty),
      .price       (price_a[i]),
      .qty         (qty_a[i]),
      .ahead       (ahead_a[i]),
      .match       (match_a[i])
    );
  end

  assign head_price = price_a[0];
  assign head_qty   = qty_a[0];
  assign count      = count_r;

endmodule

@@ rtl/price_level_order_book_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book_core
// Level-2 order book: two sorted price-level chains with top-of-book report.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (valid/ready) carries one item: cmd, side, level_price, level_qty.
//          cmd clears both sides; otherwise the item sets or erases one level (a zero price is rejected).
//   out_ch (valid/ready) carries one report per item: status, best bid and
//          ask with quantities, level counts, book_valid and the spread.
//   An item's report follows these steps once the item is accepted: compare
//   in every cell, shift/load along the cell chain, load the report register.
//   One item is in flight at a time, so no new item is taken until the
//   previous one has left the compare-then-shift sequence and its report step.
//   The output register parts the two sides: a new item is taken while the
//   previous report still waits. If the receiver stalls, the next report
//   waits in the report step and no further item is taken until it moves.
//   Synchronous reset empties both sides and drops any item in flight; the
//   level storage itself is not cleared, only the counts.
// ----------------------------------------------------------------------------
module price_level_order_book_core #(
  parameter int LEVELS     = plob_pkg::LEVELS_DEF,
  parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS   = plob_pkg::QTY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  plob_in_if.sink    in_ch,
  plob_out_if.source out_ch
);

  localparam int CNT_BITS = $clog2(LEVELS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CMP    = 4'b0010,
    S_APPLY  = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic                  cmd_r;
  logic                  side_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [QTY_BITS-1:0]   qty_r;

  logic                  out_valid_r;
  logic [1:0]            status_r;
  logic [PRICE_BITS-1:0] bb_price_r;
  logic [QTY_BITS-1:0]   bb_qty_r;
  logic [PRICE_BITS-1:0] ba_price_r;
  logic [QTY_BITS-1:0]   ba_qty_r;
  logic [CNT_BITS-1:0]   bid_cnt_r;
  logic [CNT_BITS-1:0]   ask_cnt_r;
  logic                  book_valid_r;
  logic [PRICE_BITS:0]   spread_r;

  plob_pkg::side_ctl_t   bid_ctl;
  plob_pkg::side_ctl_t   ask_ctl;
  logic [PRICE_BITS-1:0] bid_head_price;
  logic [QTY_BITS-1:0]   bid_head_qty;
  logic [CNT_BITS-1:0]   bid_cnt;
  logic [PRICE_BITS-1:0] ask_head_price;
  logic [QTY_BITS-1:0]   ask_head_qty;
  logic [CNT_BITS-1:0]   ask_cnt;

  logic                  in_fire;
  logic                  out_fire;
  logic                  slot_free;
  logic                  do_update;
  logic                  do_clear;
  logic                  have_bid;
  logic                  have_ask;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_valid_r && out_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  assign do_clear  = cmd_r == plob_pkg::CMD_CLEAR;
  assign do_update = (cmd_r == plob_pkg::CMD_UPDATE) && (price_r != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_CMP;
      S_CMP:    state_nxt = S_APPLY;
      S_APPLY:  state_nxt = S_REPORT;
      S_REPORT: if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ch.ready = state_r == S_IDLE;

  // hold the item for the whole sequence
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_ch.cmd;
      side_r  <= in_ch.side;
      price_r <= in_ch.level_price;
      qty_r   <= in_ch.level_qty;
    end
  end

  always_comb begin
    bid_ctl.cmp   = state_r == S_CMP;
    bid_ctl.apply = (state_r == S_APPLY) && do_update && (side_r == plob_pkg::SIDE_BID);
    bid_ctl.clear = (state_r == S_APPLY) && do_clear;
    ask_ctl.cmp   = state_r == S_CMP;
    ask_ctl.apply = (state_r == S_APPLY) && do_update && (side_r == plob_pkg::SIDE_ASK);
    ask_ctl.clear = (state_r == S_APPLY) && do_clear;
  end

  plob_side #(
    .LEVELS     (LEVELS),
    .PRICE_BITS (PRICE_BITS),
    .QTY_BITS   (QTY_BITS),
    .CNT_BITS   (CNT_BITS),
    .IS_ASK     (1'b0)
  ) u_bid (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (bid_ctl),
    .key_price  (price_r),
    .key_qty    (qty_r),
    .head_price (bid_head_price),
    .head_qty   (bid_head_qty),
    .count      (bid_cnt)
  );

  plob_side #(
    .LEVELS     (LEVELS),
    .PRICE_BITS (PRICE_BITS),
    .QTY_BITS   (QTY_BITS),
    .CNT_BITS   (CNT_BITS),
    .IS_ASK     (1'b1)
  ) u_ask (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ask_ctl),
    .key_price  (price_r),
    .key_qty    (qty_r),
    .head_price (ask_head_price),
    .head_qty   (ask_head_qty),
    .count      (ask_cnt)
  );

  assign have_bid = bid_cnt != '0;
  assign have_ask = ask_cnt != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_REPORT) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_REPORT) && slot_free) begin
      if (do_clear) begin
        status_r <= plob_pkg::ST_CLEARED;
      end else if (do_update) begin
        status_r <= plob_pkg::ST_APPLIED;
      end else begin
        status_r <= plob_pkg::ST_REJECTED;
      end
      bb_price_r   <= have_bid ? bid_head_price : '0;
      bb_qty_r     <= have_bid ? bid_head_qty   : '0;
      ba_price_r   <= have_ask ? ask_head_price : '0;
      ba_qty_r     <= have_ask ? ask_head_qty   : '0;
      bid_cnt_r    <= bid_cnt;
      ask_cnt_r    <= ask_cnt;
      book_valid_r <= have_bid && have_ask;
      spread_r     <= (have_bid && have_ask)
                      ? ({1'b0, ask_head_price} - {1'b0, bid_head_price}) : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.top_bid_price = bb_price_r;
  assign out_ch.best_bid_qty  = bb_qty_r;
  assign out_ch.top_ask_price = ba_price_r;
  assign out_ch.best_ask_qty  = ba_qty_r;
  assign out_ch.bid_count     = bid_cnt_r;
  assign out_ch.ask_count     = ask_cnt_r;
  assign out_ch.book_valid    = book_valid_r;
  assign out_ch.spread        = spread_r;

endmodule
